FILE: design/rcpw_pkg.sv
package rcpw_pkg;

  // Default widths of the output coordinates and of the byte address
  localparam int unsigned COORD_WIDTH_DEF = 12;
  localparam int unsigned ADDR_WIDTH_DEF  = 26;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register widths
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned BPP_W    = 6;
  localparam int unsigned LAYOUT_W = 31;

  // Counter widths and full-precision coordinate width
  localparam int unsigned POS_W = 12;
  localparam int unsigned XY_W  = COUNT_W + DIM_W;

  localparam logic [DIM_W-1:0] MAX_RECT_DIM = DIM_W'(4096);
  localparam logic [BPP_W-1:0] FULL_DEPTH   = BPP_W'(32);

  // Layout register fields
  localparam int unsigned DIRECT_BIT = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_WIDTH,
    REG_RECT_WIDTH,
    REG_RECT_HEIGHT,
    REG_RECT_COUNT,
    REG_FIRST_COLOR,
    REG_COLOR_STEP,
    REG_BITS_PER_PIXEL,
    REG_COLOR_LAYOUT
  } cfg_reg_e;

  localparam logic [DIM_W-1:0]    LINE_WIDTH_RST  = DIM_W'(1024);
  localparam logic [DIM_W-1:0]    RECT_WIDTH_RST  = DIM_W'(128);
  localparam logic [DIM_W-1:0]    RECT_HEIGHT_RST = DIM_W'(96);
  localparam logic [COUNT_W-1:0]  RECT_COUNT_RST  = COUNT_W'(8);
  localparam logic [COLOR_W-1:0]  FIRST_COLOR_RST = '0;
  localparam logic [STEP_W-1:0]   COLOR_STEP_RST  = STEP_W'(1);
  localparam logic [BPP_W-1:0]    BPP_RST         = BPP_W'(8);
  localparam logic [LAYOUT_W-1:0] LAYOUT_RST      = '0;

endpackage

FILE: design/rcpw_if.sv
interface rcpw_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rcpw_pix_if #(
  parameter int unsigned COORD_WIDTH = rcpw_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH  = rcpw_pkg::ADDR_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH-1:0] pixel_x;
  logic [COORD_WIDTH-1:0] pixel_y;
  logic [ADDR_WIDTH-1:0]  byte_address;
  logic [31:0]            pixel_color;
  logic                   last_pixel;

  modport source (output valid, output pixel_x, output pixel_y, output byte_address,
                  output pixel_color, output last_pixel, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input byte_address,
                  input pixel_color, input last_pixel, output ready);
endinterface

FILE: design/rect_color_pattern_writer_top.sv
// Rectangle grid pattern writer.
// Each transaction on req_i is one tick: restart=1 starts the pattern at its
// first pixel, restart=0 advances by one pixel. A tick that produces a pixel
// gives one transaction on pix_o with the pixel's x, y, framebuffer byte
// address and color; last_pixel marks the final pixel of the grid. Ticks
// while the pattern is idle or finished give nothing.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i;
// the user must do so only while no tick is in flight, as the block does not
// enforce it. The new values apply from the next tick.
// Each pixel passes the four-stage pipeline (counters, coordinate products,
// linear index and color, byte scaling), which holds one item per stage and
// takes one tick per cycle while pix_o does not stall.
// When pix_o stalls the whole pipeline holds and req_i.ready drops, so no
// pixel is lost; req_i.ready stays high while the output register is empty
// or being taken.
// Reset (asynchronous, active low) loads the register defaults, empties the
// pipeline and leaves the pattern idle until a restart tick.
module rect_color_pattern_writer_top #(
  parameter int unsigned COORD_WIDTH = rcpw_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ADDR_WIDTH  = rcpw_pkg::ADDR_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [rcpw_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rcpw_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  rcpw_req_if.sink                           req_i,
  rcpw_pix_if.source                         pix_o
);
  import rcpw_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]    line_width_q, rect_width_q, rect_height_q;
  logic [COUNT_W-1:0]  rect_count_q;
  logic [COLOR_W-1:0]  first_color_q;
  logic [STEP_W-1:0]   color_step_q;
  logic [BPP_W-1:0]    bpp_q;
  logic [LAYOUT_W-1:0] color_layout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q   <= LINE_WIDTH_RST;
      rect_width_q   <= RECT_WIDTH_RST;
      rect_height_q  <= RECT_HEIGHT_RST;
      rect_count_q   <= RECT_COUNT_RST;
      first_color_q  <= FIRST_COLOR_RST;
      color_step_q   <= COLOR_STEP_RST;
      bpp_q          <= BPP_RST;
      color_layout_q <= LAYOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LINE_WIDTH:     line_width_q   <= cfg_data_i[DIM_W-1:0];
        REG_RECT_WIDTH:     rect_width_q   <= cfg_data_i[DIM_W-1:0];
        REG_RECT_HEIGHT:    rect_height_q  <= cfg_data_i[DIM_W-1:0];
        REG_RECT_COUNT:     rect_count_q   <= cfg_data_i[COUNT_W-1:0];
        REG_FIRST_COLOR:    first_color_q  <= cfg_data_i[COLOR_W-1:0];
        REG_COLOR_STEP:     color_step_q   <= cfg_data_i[STEP_W-1:0];
        REG_BITS_PER_PIXEL: bpp_q          <= cfg_data_i[BPP_W-1:0];
        REG_COLOR_LAYOUT:   color_layout_q <= cfg_data_i[LAYOUT_W-1:0];
        default:            ;
      endcase
    end
  end

  // Derived configuration
  logic [DIM_W-1:0]   rect_w, rect_h;
  logic [BPP_W-1:0]   depth;
  logic [COLOR_W-1:0] depth_mask;
  logic [2:0]         bytes_pp;
  logic [BPP_W:0]     depth_round;

  assign rect_w      = (rect_width_q > MAX_RECT_DIM) ? MAX_RECT_DIM : rect_width_q;
  assign rect_h      = (rect_height_q > MAX_RECT_DIM) ? MAX_RECT_DIM : rect_height_q;
  assign depth       = (bpp_q > FULL_DEPTH) ? FULL_DEPTH : bpp_q;
  assign depth_mask  = depth[5] ? '1 : ((COLOR_W'(1) << depth[4:0]) - COLOR_W'(1));
  assign depth_round = {1'b0, depth} + (BPP_W+1)'(7);
  assign bytes_pp    = depth_round[5:3];

  // Pipeline control: the whole pipeline moves when the output register frees
  logic adv, accept;
  logic out_valid_q;

  assign adv         = !out_valid_q || pix_o.ready;
  assign req_i.ready = adv;
  assign accept      = req_i.valid && adv;

  // Pattern position of the next pixel
  logic [COUNT_W-1:0] row_q, col_q, row_d, col_d;
  logic [POS_W-1:0]   line_q, pix_q, line_d, pix_d;
  logic               active_q, active_d;

  logic [COUNT_W-1:0] row_b, col_b;
  logic [POS_W-1:0]   line_b, pix_b;
  logic               active_b, empty_grid, emit, last;
  logic [DIM_W-1:0]   pix_inc, line_inc;
  logic [COUNT_W:0]   col_inc, row_inc;

  always_comb begin
    row_b    = req_i.restart ? '0 : row_q;
    col_b    = req_i.restart ? '0 : col_q;
    line_b   = req_i.restart ? '0 : line_q;
    pix_b    = req_i.restart ? '0 : pix_q;
    active_b = req_i.restart || active_q;

    empty_grid = (rect_count_q == '0) || (rect_w == '0) || (rect_h == '0);
    emit       = active_b && !empty_grid;

    pix_inc  = {1'b0, pix_b} + DIM_W'(1);
    line_inc = {1'b0, line_b} + DIM_W'(1);
    col_inc  = {1'b0, col_b} + (COUNT_W+1)'(1);
    row_inc  = {1'b0, row_b} + (COUNT_W+1)'(1);

    row_d    = row_b;
    col_d    = col_b;
    line_d   = line_b;
    pix_d    = pix_b;
    active_d = emit;
    last     = 1'b0;

    // Advance: pixel, then line, then rectangle, then rectangle row
    if (emit) begin
      pix_d = pix_inc[POS_W-1:0];
      if (pix_inc >= rect_w) begin
        pix_d  = '0;
        line_d = line_inc[POS_W-1:0];
        if (line_inc >= rect_h) begin
          line_d = '0;
          col_d  = col_inc[COUNT_W-1:0];
          if (col_inc >= {1'b0, rect_count_q}) begin
            col_d = '0;
            row_d = row_inc[COUNT_W-1:0];
            if (row_inc >= {1'b0, rect_count_q}) begin
              row_d    = '0;
              last     = 1'b1;
              active_d = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      line_q   <= '0;
      pix_q    <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      row_q    <= row_d;
      col_q    <= col_d;
      line_q   <= line_d;
      pix_q    <= pix_d;
      active_q <= active_d;
    end
  end

  // Stage 1: position of the emitted pixel
  logic               s1_valid_q;
  logic [COUNT_W-1:0] s1_row_q, s1_col_q;
  logic [POS_W-1:0]   s1_line_q, s1_pix_q;
  logic               s1_last_q;

  // Stage 2: coordinates and colour products
  logic                    s2_valid_q;
  logic [XY_W-1:0]         s2_x_q, s2_y_q;
  logic [2*COUNT_W-1:0]    s2_idx_q;
  logic [COUNT_W+STEP_W-1:0] s2_radd_q, s2_gadd_q;
  logic [COUNT_W+STEP_W:0] s2_badd_q;
  logic                    s2_last_q;

  logic [XY_W-1:0]           col_w, row_h, s2_x_d, s2_y_d;
  logic [2*COUNT_W-1:0]      row_n, s2_idx_d;
  logic [COUNT_W:0]          row_col;
  logic [COUNT_W+STEP_W-1:0] s2_radd_d, s2_gadd_d;
  logic [COUNT_W+STEP_W:0]   s2_badd_d;

  assign col_w     = s1_col_q * rect_w;
  assign row_h     = s1_row_q * rect_h;
  assign s2_x_d    = col_w + XY_W'(s1_pix_q);
  assign s2_y_d    = row_h + XY_W'(s1_line_q);
  assign row_n     = s1_row_q * rect_count_q;
  assign s2_idx_d  = row_n + (2*COUNT_W)'(s1_col_q);
  assign row_col   = {1'b0, s1_row_q} + {1'b0, s1_col_q};
  assign s2_radd_d = s1_col_q * color_step_q;
  assign s2_gadd_d = s1_row_q * color_step_q;
  assign s2_badd_d = row_col * color_step_q;

  // Stage 3: linear pixel index and colour
  logic                   s3_valid_q;
  logic [ADDR_WIDTH-1:0]  s3_lin_q;
  logic [COORD_WIDTH-1:0] s3_x_q, s3_y_q;
  logic [COLOR_W-1:0]     s3_color_q;
  logic                   s3_last_q;

  logic [XY_W+DIM_W:0]         lin_full;
  logic [2*COUNT_W+STEP_W-1:0] idx_step;
  logic [COLOR_W-1:0]          idx_color, dir_color, s3_color_d;

  function automatic logic [COLOR_W-1:0] channel(input logic [COLOR_W-1:0] first,
                                                 input logic [4:0] pos,
                                                 input logic [4:0] size,
                                                 input logic [COUNT_W+STEP_W:0] add);
    logic [COLOR_W-1:0] m;
    logic [COLOR_W-1:0] f;
    m = (COLOR_W'(1) << size) - COLOR_W'(1);
    f = ((first >> pos) & m) + COLOR_W'(add);
    return (f & m) << pos;
  endfunction

  assign lin_full  = s2_y_q * line_width_q + s2_x_q;
  assign idx_step  = s2_idx_q * color_step_q;
  assign idx_color = first_color_q + COLOR_W'(idx_step);
  assign dir_color = channel(first_color_q, color_layout_q[4:0], color_layout_q[9:5],
                             {1'b0, s2_radd_q})
                   | channel(first_color_q, color_layout_q[14:10], color_layout_q[19:15],
                             {1'b0, s2_gadd_q})
                   | channel(first_color_q, color_layout_q[24:20], color_layout_q[29:25],
                             s2_badd_q);
  assign s3_color_d = (color_layout_q[DIRECT_BIT] ? dir_color : idx_color) & depth_mask;

  // Output stage: scale by bytes per pixel
  logic [ADDR_WIDTH-1:0]  addr_d;
  logic [COORD_WIDTH-1:0] out_x_q, out_y_q;
  logic [ADDR_WIDTH-1:0]  out_addr_q;
  logic [COLOR_W-1:0]     out_color_q;
  logic                   out_last_q;

  always_comb begin
    case (bytes_pp)
      3'd0:    addr_d = '0;
      3'd1:    addr_d = s3_lin_q;
      3'd2:    addr_d = s3_lin_q << 1;
      3'd3:    addr_d = s3_lin_q + (s3_lin_q << 1);
      default: addr_d = s3_lin_q << 2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= accept && emit;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  // Payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_row_q    <= row_b;
      s1_col_q    <= col_b;
      s1_line_q   <= line_b;
      s1_pix_q    <= pix_b;
      s1_last_q   <= last;

      s2_x_q      <= s2_x_d;
      s2_y_q      <= s2_y_d;
      s2_idx_q    <= s2_idx_d;
      s2_radd_q   <= s2_radd_d;
      s2_gadd_q   <= s2_gadd_d;
      s2_badd_q   <= s2_badd_d;
      s2_last_q   <= s1_last_q;

      s3_lin_q    <= lin_full[ADDR_WIDTH-1:0];
      s3_x_q      <= s2_x_q[COORD_WIDTH-1:0];
      s3_y_q      <= s2_y_q[COORD_WIDTH-1:0];
      s3_color_q  <= s3_color_d;
      s3_last_q   <= s2_last_q;

      out_x_q     <= s3_x_q;
      out_y_q     <= s3_y_q;
      out_addr_q  <= addr_d;
      out_color_q <= s3_color_q;
      out_last_q  <= s3_last_q;
    end
  end

  assign pix_o.valid        = out_valid_q;
  assign pix_o.pixel_x      = out_x_q;
  assign pix_o.pixel_y      = out_y_q;
  assign pix_o.byte_address = out_addr_q;
  assign pix_o.pixel_color  = out_color_q;
  assign pix_o.last_pixel   = out_last_q;

endmodule
